/* rtl/core/fib_pkg.sv */
// Shared types, constants and helper functions for the framebuffer image blit.
// Used by every module of the block; depends on nothing else.
package fib_pkg;

  // Largest rectangle side in pixels, and the counter width it needs.
  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM);

  // Fixed field widths.
  localparam int ADDR_W = 32;
  localparam int LINE_W = 11;
  localparam int ORG_W  = 10;
  localparam int RECT_W = 11;
  localparam int MODE_W = 2;
  localparam int DATA_W = 24;
  localparam int SIZE_W = 2;
  localparam int BYTE_W = 8;
  localparam int PART_W = 16;
  localparam int PHASE_W = 2;

  // Pixel index inside the framebuffer: line * (origin_row + row) + origin_col + col.
  localparam int SPAN_W = (ORG_W > DIM_W) ? ORG_W : DIM_W;
  localparam int IDX_W  = LINE_W + SPAN_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd6;

  // Pixel modes.
  localparam logic [MODE_W-1:0] MODE_8BPP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16BPP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_24BPP = 2'd2;

  // Write sizes.
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

  // Reset values of the registers.
  localparam logic [LINE_W-1:0] LINE_PIXELS_RST = 11'd480;
  localparam logic [MODE_W-1:0] PIXEL_MODE_RST  = MODE_16BPP;
  localparam logic [RECT_W-1:0] RECT_DIM_RST    = 11'd1;

  // Depth of the queue between the byte assembler and the address generator.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One assembled pixel on its way to the address generator.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] size;
  } pix_t;

  // Decoded configuration as the address generator sees it.
  typedef struct packed {
    logic [ADDR_W-1:0] frame_base;
    logic [LINE_W-1:0] line_pixels;
    logic [DIM_W-1:0]  w_last;
    logic [DIM_W-1:0]  h_last;
    logic [IDX_W-1:0]  origin_base;
  } cfg_t;

  // Restart control: restart on the write edge, reload of bases in the cycle after it.
  typedef struct packed {
    logic restart;
    logic reload;
  } ctl_t;

  // Mode three behaves as 24 bpp.
  function automatic logic [MODE_W-1:0] mode_eff(input logic [MODE_W-1:0] m);
    logic [MODE_W-1:0] r;
    r = (m >= MODE_24BPP) ? MODE_24BPP : m;
    return r;
  endfunction

  // Index of the last pixel along one side: zero acts as one, oversize as MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_last(input logic [RECT_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - RECT_W'(1));
    end
    return r;
  endfunction

endpackage

/* rtl/core/framebuffer_image_blit_core.sv */
// Framebuffer image blit, top level: configuration registers, byte assembler,
// pixel queue and address generator. Depends on fib_pkg and the fib_* modules.
//
// The block takes one picture byte per clock while in_stall is low and, for
// each finished 8, 16 or 24 bpp pixel, issues one framebuffer write with its
// byte address, data, size and a flag on the rectangle's final pixel.
// Sustained rate is one byte per cycle while the output is not stalled; the
// pixel enters the queue at the edge that accepts its last byte and moves on
// into the output register once that register is free. While the consumer
// stalls, the queue takes two more pixels behind the held write before
// in_stall rises. The rate is set by the address generator, which advances
// the pixel index by a single add per pixel. Any write to a known register
// restarts the blit at the rectangle's top-left corner; the next byte may be
// offered on the following cycle.
module framebuffer_image_blit_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fib_pkg::BYTE_W-1:0]     in_picture_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fib_pkg::ADDR_W-1:0]     out_write_address,
  output logic [fib_pkg::DATA_W-1:0]     out_write_data,
  output logic [fib_pkg::SIZE_W-1:0]     out_write_size,
  output logic                           out_last_pixel,
  input  logic                           cfg_we,
  input  logic [fib_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fib_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [fib_pkg::MODE_W-1:0] pixel_mode;
  fib_pkg::cfg_t              cfg;
  fib_pkg::ctl_t              ctl;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_not_empty;
  fib_pkg::pix_t              push_pix;
  fib_pkg::pix_t              pop_pix;

  // Configuration registers.
  fib_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pixel_mode (pixel_mode),
    .cfg        (cfg),
    .ctl        (ctl)
  );

  // Byte assembly.
  fib_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_picture_byte (in_picture_byte),
    .pixel_mode      (pixel_mode),
    .restart         (ctl.restart),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_pix           (push_pix)
  );

  // Pixel queue.
  fib_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_pix  (push_pix),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_pix   (pop_pix)
  );

  // Address generation and output register.
  fib_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .ctl               (ctl),
    .q_not_empty       (q_not_empty),
    .q_pix             (pop_pix),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_size    (out_write_size),
    .out_last_pixel    (out_last_pixel)
  );

endmodule

/* rtl/core/fib_cfg.sv */
// Configuration register file of the blit, with the rectangle's origin index.
// Depends on fib_pkg.
module fib_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fib_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fib_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [fib_pkg::MODE_W-1:0]     pixel_mode,
  output fib_pkg::cfg_t                  cfg,
  output fib_pkg::ctl_t                  ctl
);

  logic [fib_pkg::ADDR_W-1:0] frame_base_r,  frame_base_nxt;
  logic [fib_pkg::LINE_W-1:0] line_pixels_r, line_pixels_nxt;
  logic [fib_pkg::MODE_W-1:0] pixel_mode_r,  pixel_mode_nxt;
  logic [fib_pkg::ORG_W-1:0]  origin_col_r,  origin_col_nxt;
  logic [fib_pkg::ORG_W-1:0]  origin_row_r,  origin_row_nxt;
  logic [fib_pkg::RECT_W-1:0] rect_width_r,  rect_width_nxt;
  logic [fib_pkg::RECT_W-1:0] rect_height_r, rect_height_nxt;
  logic [fib_pkg::IDX_W-1:0]  origin_base_r, origin_base_nxt;
  logic                       reload_r;
  logic                       hit;

  // Register decode; an unknown index is ignored and does not restart.
  always_comb begin
    frame_base_nxt  = frame_base_r;
    line_pixels_nxt = line_pixels_r;
    pixel_mode_nxt  = pixel_mode_r;
    origin_col_nxt  = origin_col_r;
    origin_row_nxt  = origin_row_r;
    rect_width_nxt  = rect_width_r;
    rect_height_nxt = rect_height_r;
    hit             = 1'b0;
    if (cfg_we) begin
      hit = 1'b1;
      unique case (cfg_index)
        fib_pkg::REG_FRAME_BASE:  frame_base_nxt  = cfg_wdata[fib_pkg::ADDR_W-1:0];
        fib_pkg::REG_LINE_PIXELS: line_pixels_nxt = cfg_wdata[fib_pkg::LINE_W-1:0];
        fib_pkg::REG_PIXEL_MODE:  pixel_mode_nxt  = cfg_wdata[fib_pkg::MODE_W-1:0];
        fib_pkg::REG_ORIGIN_COL:  origin_col_nxt  = cfg_wdata[fib_pkg::ORG_W-1:0];
        fib_pkg::REG_ORIGIN_ROW:  origin_row_nxt  = cfg_wdata[fib_pkg::ORG_W-1:0];
        fib_pkg::REG_RECT_WIDTH:  rect_width_nxt  = cfg_wdata[fib_pkg::RECT_W-1:0];
        fib_pkg::REG_RECT_HEIGHT: rect_height_nxt = cfg_wdata[fib_pkg::RECT_W-1:0];
        default:                  hit             = 1'b0;
      endcase
    end
  end

  // Pixel index of the rectangle's top-left corner, from the values after the write.
  assign origin_base_nxt = fib_pkg::IDX_W'(fib_pkg::IDX_W'(line_pixels_nxt) *
                                           fib_pkg::IDX_W'(origin_row_nxt)) +
                           fib_pkg::IDX_W'(origin_col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r  <= '0;
      line_pixels_r <= fib_pkg::LINE_PIXELS_RST;
      pixel_mode_r  <= fib_pkg::PIXEL_MODE_RST;
      origin_col_r  <= '0;
      origin_row_r  <= '0;
      rect_width_r  <= fib_pkg::RECT_DIM_RST;
      rect_height_r <= fib_pkg::RECT_DIM_RST;
      origin_base_r <= '0;
      reload_r      <= 1'b0;
    end else begin
      frame_base_r  <= frame_base_nxt;
      line_pixels_r <= line_pixels_nxt;
      pixel_mode_r  <= pixel_mode_nxt;
      origin_col_r  <= origin_col_nxt;
      origin_row_r  <= origin_row_nxt;
      rect_width_r  <= rect_width_nxt;
      rect_height_r <= rect_height_nxt;
      origin_base_r <= origin_base_nxt;
      reload_r      <= hit;
    end
  end

  assign pixel_mode      = fib_pkg::mode_eff(pixel_mode_r);
  assign cfg.frame_base  = frame_base_r;
  assign cfg.line_pixels = line_pixels_r;
  assign cfg.w_last      = fib_pkg::dim_last(rect_width_r);
  assign cfg.h_last      = fib_pkg::dim_last(rect_height_r);
  assign cfg.origin_base = origin_base_r;
  assign ctl.restart     = hit;
  assign ctl.reload      = reload_r;

endmodule

/* rtl/core/fib_front.sv */
// Front end of the blit: takes picture bytes and assembles them into pixels.
// Depends on fib_pkg; feeds fib_queue.
module fib_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fib_pkg::BYTE_W-1:0] in_picture_byte,
  input  logic [fib_pkg::MODE_W-1:0] pixel_mode,
  input  logic                       restart,
  input  logic                       q_full,
  output logic                       q_push,
  output fib_pkg::pix_t              q_pix
);

  logic [fib_pkg::PHASE_W-1:0] phase_r,   phase_nxt;
  logic [fib_pkg::PART_W-1:0]  partial_r, partial_nxt;
  logic [fib_pkg::DATA_W-1:0]  acc;
  logic                        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign acc      = {partial_r, in_picture_byte};

  // Shift bytes in until the mode's pixel is complete, then hand it on.
  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    q_push      = 1'b0;
    q_pix.data  = acc;
    q_pix.size  = fib_pkg::SIZE_WORD;
    unique case (pixel_mode)
      fib_pkg::MODE_8BPP: begin
        q_pix.data = fib_pkg::DATA_W'(in_picture_byte);
        q_pix.size = fib_pkg::SIZE_BYTE;
      end
      fib_pkg::MODE_16BPP: begin
        q_pix.data = fib_pkg::DATA_W'(acc[fib_pkg::PART_W-1:0]);
        q_pix.size = fib_pkg::SIZE_HALF;
      end
      default: begin
        q_pix.data = acc;
        q_pix.size = fib_pkg::SIZE_WORD;
      end
    endcase
    if (restart) begin
      phase_nxt   = '0;
      partial_nxt = '0;
    end else if (accept) begin
      if (fib_pkg::MODE_W'(phase_r) < pixel_mode) begin
        partial_nxt = acc[fib_pkg::PART_W-1:0];
        phase_nxt   = phase_r + fib_pkg::PHASE_W'(1);
      end else begin
        q_push      = 1'b1;
        phase_nxt   = '0;
        partial_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      partial_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

/* rtl/core/fib_queue.sv */
// Short queue of assembled pixels between the front end and the address generator.
// Depends on fib_pkg.
module fib_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fib_pkg::pix_t push_pix,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output fib_pkg::pix_t pop_pix
);

  fib_pkg::pix_t               mem_r [fib_pkg::QDEPTH];
  logic [fib_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [fib_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [fib_pkg::QCNT_W-1:0]  cnt_r,    cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full      = (cnt_r == fib_pkg::QCNT_W'(fib_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_pix   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fib_pkg::QPTR_W'(fib_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + fib_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fib_pkg::QPTR_W'(fib_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + fib_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + fib_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - fib_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pix;
    end
  end

endmodule

/* rtl/core/fib_back.sv */
// Back end of the blit: walks the rectangle, forms write addresses and holds the
// output register. Depends on fib_pkg; fed by fib_queue.
module fib_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fib_pkg::cfg_t              cfg,
  input  fib_pkg::ctl_t              ctl,
  input  logic                       q_not_empty,
  input  fib_pkg::pix_t              q_pix,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fib_pkg::ADDR_W-1:0] out_write_address,
  output logic [fib_pkg::DATA_W-1:0] out_write_data,
  output logic [fib_pkg::SIZE_W-1:0] out_write_size,
  output logic                       out_last_pixel
);

  logic [fib_pkg::DIM_W-1:0]  col_r,      col_nxt;
  logic [fib_pkg::DIM_W-1:0]  row_r,      row_nxt;
  logic [fib_pkg::IDX_W-1:0]  row_base_r, row_base_nxt;
  logic [fib_pkg::IDX_W-1:0]  cur_r,      cur_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [fib_pkg::ADDR_W-1:0] addr_r;
  logic [fib_pkg::DATA_W-1:0] data_r;
  logic [fib_pkg::SIZE_W-1:0] size_r;
  logic                       last_r;
  logic [fib_pkg::ADDR_W-1:0] byte_off;
  logic [fib_pkg::ADDR_W-1:0] addr;
  logic [fib_pkg::IDX_W-1:0]  next_row_base;
  logic                       col_end;
  logic                       row_end;
  logic                       take;

  assign take  = q_not_empty && (!out_valid_r || !out_stall);
  assign q_pop = take;

  // Byte address: pixel index scaled by the stored pixel size, plus the frame base.
  always_comb begin
    unique case (q_pix.size)
      fib_pkg::SIZE_BYTE: byte_off = fib_pkg::ADDR_W'(cur_r);
      fib_pkg::SIZE_HALF: byte_off = fib_pkg::ADDR_W'(cur_r) << 1;
      default:            byte_off = fib_pkg::ADDR_W'(cur_r) << 2;
    endcase
  end
  assign addr = cfg.frame_base + byte_off;

  assign col_end       = (col_r == cfg.w_last);
  assign row_end       = (row_r == cfg.h_last);
  assign next_row_base = row_base_r + fib_pkg::IDX_W'(cfg.line_pixels);

  // Column and row walk; the pixel index moves by one column or one line.
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    cur_nxt      = cur_r;
    if (ctl.restart || ctl.reload) begin
      col_nxt = '0;
      row_nxt = '0;
      if (ctl.reload) begin
        row_base_nxt = cfg.origin_base;
        cur_nxt      = cfg.origin_base;
      end
    end else if (take) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt      = '0;
          row_base_nxt = cfg.origin_base;
          cur_nxt      = cfg.origin_base;
        end else begin
          row_nxt      = row_r + fib_pkg::DIM_W'(1);
          row_base_nxt = next_row_base;
          cur_nxt      = next_row_base;
        end
      end else begin
        col_nxt = col_r + fib_pkg::DIM_W'(1);
        cur_nxt = cur_r + fib_pkg::IDX_W'(1);
      end
    end
  end

  // Output register holds a write until the consumer takes it.
  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      row_base_r  <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_base_r  <= row_base_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r <= addr;
      data_r <= q_pix.data;
      size_r <= q_pix.size;
      last_r <= col_end && row_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;
  assign out_write_size    = size_r;
  assign out_last_pixel    = last_r;

endmodule

/* rtl/core/fib_checker.sv */
// Port-level checks for the framebuffer image blit, bound to the top level.
// Depends on fib_pkg and framebuffer_image_blit_core.
module fib_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [fib_pkg::ADDR_W-1:0] out_write_address,
  input logic [fib_pkg::DATA_W-1:0] out_write_data,
  input logic [fib_pkg::SIZE_W-1:0] out_write_size,
  input logic                       out_last_pixel
);

  // A stalled write keeps its address and data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_address) &&
                               $stable(out_write_data) && $stable(out_write_size) &&
                               $stable(out_last_pixel))
    else $error("stalled write changed");

  // A byte write carries only the 8-bit index.
  a_byte_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_size == fib_pkg::SIZE_BYTE |->
      out_write_data[fib_pkg::DATA_W-1:fib_pkg::BYTE_W] == '0)
    else $error("byte write with upper data bits set");

  // A halfword write carries only the 16-bit value.
  a_half_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_size == fib_pkg::SIZE_HALF |->
      out_write_data[fib_pkg::DATA_W-1:fib_pkg::PART_W] == '0)
    else $error("halfword write with upper data bits set");

  // No write is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("write offered after reset");

endmodule

bind framebuffer_image_blit_core fib_checker u_fib_checker (.*);

/* tb/fib_write_checker.sv */
// Write checker for the framebuffer image blit: tracks register writes and picture bytes,
// predicts each pixel write and compares it with what the block issues.
// Depends on fib_pkg for widths, register indexes, pixel modes and write sizes.
module fib_write_checker
  import fib_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_picture_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [ADDR_W-1:0]     out_write_address,
  input  logic [DATA_W-1:0]     out_write_data,
  input  logic [SIZE_W-1:0]     out_write_size,
  input  logic                  out_last_pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    writes_waiting,
  output int                    writes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] size;
    logic              last;
  } pixel_write_t;

  // Pixel writes predicted but not yet seen on the output, oldest first.
  pixel_write_t expected_writes[$];

  // Register copy.
  logic [ADDR_W-1:0] fb_base;
  logic [LINE_W-1:0] fb_line;
  logic [MODE_W-1:0] px_mode;
  logic [ORG_W-1:0]  org_col;
  logic [ORG_W-1:0]  org_row;
  logic [RECT_W-1:0] pic_w;
  logic [RECT_W-1:0] pic_h;

  // Blit progress.
  logic [PHASE_W-1:0] bytes_in;
  logic [PART_W-1:0]  held_bytes;
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [ADDR_W-1:0]  row_addr;

  // Mode three stores like 24 bpp.
  function automatic logic [MODE_W-1:0] active_mode();
    return (px_mode > MODE_24BPP) ? MODE_24BPP : px_mode;
  endfunction

  function automatic int unsigned bytes_per_store();
    case (active_mode())
      MODE_8BPP:  return 1;
      MODE_16BPP: return 2;
      default:    return 4;
    endcase
  endfunction

  // A zero side counts as one pixel, an oversized side as the largest one.
  function automatic int unsigned clamp_side(input logic [RECT_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Byte address of the first pixel of the current row, modulo 2^32.
  task automatic locate_row();
    longint unsigned offset;
    offset = longint'(fb_line) * (longint'(org_row) + cur_row) * bytes_per_store();
    row_addr = ADDR_W'(longint'(fb_base) + offset);
  endtask

  task automatic restart_blit();
    bytes_in   = '0;
    held_bytes = '0;
    cur_col    = 0;
    cur_row    = 0;
    locate_row();
  endtask

  task automatic load_defaults();
    fb_base = '0;
    fb_line = LINE_PIXELS_RST;
    px_mode = PIXEL_MODE_RST;
    org_col = '0;
    org_row = '0;
    pic_w   = RECT_DIM_RST;
    pic_h   = RECT_DIM_RST;
    restart_blit();
  endtask

  // Any known register write restarts the blit; an unknown index is ignored.
  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FRAME_BASE:  fb_base = val[ADDR_W-1:0];
      REG_LINE_PIXELS: fb_line = val[LINE_W-1:0];
      REG_PIXEL_MODE:  px_mode = val[MODE_W-1:0];
      REG_ORIGIN_COL:  org_col = val[ORG_W-1:0];
      REG_ORIGIN_ROW:  org_row = val[ORG_W-1:0];
      REG_RECT_WIDTH:  pic_w   = val[RECT_W-1:0];
      REG_RECT_HEIGHT: pic_h   = val[RECT_W-1:0];
      default:         return;
    endcase
    restart_blit();
  endtask

  // Take one picture byte; queue a pixel write once the pixel is complete.
  task automatic predict_pixel_write(input logic [BYTE_W-1:0] b);
    logic [DATA_W-1:0] joined;
    logic [MODE_W-1:0] m;
    pixel_write_t      w;
    int unsigned       bpb;
    int unsigned       wd;
    int unsigned       ht;
    m      = active_mode();
    joined = {held_bytes, b};
    // Still short of a full pixel: hold the byte.
    if (bytes_in < m) begin
      held_bytes = joined[PART_W-1:0];
      bytes_in   = bytes_in + 1'b1;
      return;
    end
    case (m)
      MODE_8BPP: begin
        w.data = DATA_W'(b);
        w.size = SIZE_BYTE;
      end
      MODE_16BPP: begin
        w.data = DATA_W'(joined[PART_W-1:0]);
        w.size = SIZE_HALF;
      end
      default: begin
        w.data = joined;
        w.size = SIZE_WORD;
      end
    endcase
    bpb       = bytes_per_store();
    wd        = clamp_side(pic_w);
    ht        = clamp_side(pic_h);
    w.address = ADDR_W'(longint'(row_addr) + (longint'(org_col) + cur_col) * bpb);
    w.last    = (cur_col + 1 >= wd) && (cur_row + 1 >= ht);
    expected_writes.push_back(w);
    bytes_in   = '0;
    held_bytes = '0;
    // Step across the row, then down; wrap to the top-left after the last pixel.
    if (cur_col + 1 >= wd) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= ht) ? 0 : cur_row + 1;
      locate_row();
    end else begin
      cur_col++;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s is 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  task automatic check_pixel_write();
    pixel_write_t w;
    if (expected_writes.size() == 0) begin
      report_mismatch("write address with no pixel pending", out_write_address, '0);
      return;
    end
    w = expected_writes.pop_front();
    if (out_write_address !== w.address) begin
      report_mismatch("write_address", out_write_address, w.address);
    end
    if (out_write_data !== w.data) begin
      report_mismatch("write_data", out_write_data, w.data);
    end
    if (out_write_size !== w.size) begin
      report_mismatch("write_size", out_write_size, w.size);
    end
    if (out_last_pixel !== w.last) begin
      report_mismatch("last_pixel", out_last_pixel, w.last);
    end
    writes_checked++;
  endtask

  // Sample all channels on the clock edge, before the edge's own updates land.
  always @(posedge clk) begin
    if (!rst_n) begin
      load_defaults();
      expected_writes.delete();
    end else begin
      if (cfg_we) apply_reg_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) predict_pixel_write(in_picture_byte);
      if (out_valid && !out_stall) check_pixel_write();
    end
    writes_waiting = expected_writes.size();
  end

endmodule

/* tb/tb_framebuffer_image_blit_core.sv */
// Testbench top for framebuffer_image_blit_core: clock, reset, register programming,
// picture-byte stimulus, output stalls and the verdict.
// Depends on fib_pkg, the block itself and fib_write_checker.
module tb_framebuffer_image_blit_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fib_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED       = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_24BPP_ALIAS = 2'd3;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 12;
  localparam int MAX_GAP       = 8;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_picture_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_write_address;
  logic [DATA_W-1:0]     out_write_data;
  logic [SIZE_W-1:0]     out_write_size;
  logic                  out_last_pixel;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int writes_waiting;
  int writes_checked;
  int cycle_count = 0;
  int bytes_sent = 0;
  int settings_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  framebuffer_image_blit_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_picture_byte   (in_picture_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_size    (out_write_size),
    .out_last_pixel    (out_last_pixel),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  fib_write_checker write_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_picture_byte   (in_picture_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_size    (out_write_size),
    .out_last_pixel    (out_last_pixel),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (mismatch_count),
    .writes_waiting    (writes_waiting),
    .writes_checked    (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Run stopped at the cycle limit with %0d pixel writes outstanding.",
               writes_waiting);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one picture byte, after an optional idle gap, and wait until it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int   gap;
    logic taken;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_picture_byte <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  // Stop sending and wait until every predicted write has come out.
  task automatic drain_writes();
    in_valid <= 1'b0;
    do @(negedge clk); while (writes_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per clock; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [ADDR_W-1:0] base, input logic [LINE_W-1:0] line,
                              input logic [MODE_W-1:0] mode, input logic [ORG_W-1:0] col,
                              input logic [ORG_W-1:0] row, input logic [RECT_W-1:0] wd,
                              input logic [RECT_W-1:0] ht);
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_LINE_PIXELS, CFG_DATA_W'(line));
    write_reg(REG_PIXEL_MODE, CFG_DATA_W'(mode));
    write_reg(REG_ORIGIN_COL, CFG_DATA_W'(col));
    write_reg(REG_ORIGIN_ROW, CFG_DATA_W'(row));
    write_reg(REG_RECT_WIDTH, CFG_DATA_W'(wd));
    write_reg(REG_RECT_HEIGHT, CFG_DATA_W'(ht));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // A write to the spare index must leave the blit untouched.
  task automatic poke_unused_reg();
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ORG_W-1:0] pick_origin();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return ORG_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Random settings, weighted toward small rectangles so that they wrap often.
  task automatic program_random_settings();
    logic [ADDR_W-1:0] base;
    logic [LINE_W-1:0] line;
    logic [RECT_W-1:0] wd;
    logic [RECT_W-1:0] ht;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       line = '0;
      1:       line = '1;
      2:       line = LINE_W'(MAX_DIM);
      default: line = LINE_W'($urandom_range(1, MAX_DIM));
    endcase
    wd = ($urandom_range(0, 7) == 0) ? RECT_W'($urandom_range(0, 2047))
                                     : RECT_W'($urandom_range(0, 5));
    ht = ($urandom_range(0, 7) == 0) ? RECT_W'($urandom_range(0, 2047))
                                     : RECT_W'($urandom_range(0, 4));
    program_regs(base, line, MODE_W'($urandom_range(0, 3)), pick_origin(), pick_origin(),
                 wd, ht);
  endtask

  initial begin
    int n_bytes;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 16 bpp, single-pixel rectangle, every write is the last one.
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h12); send_byte(8'h34);
    drain_writes();

    // Register extremes: mode three, zero width, oversized height, top-end address wrap.
    // The phase ends two bytes into a pixel; the spare register must not disturb it.
    program_regs('1, '1, MODE_24BPP_ALIAS, '1, '1, '0, '1);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
    send_byte(8'h7F); send_byte(8'h80);
    drain_writes();
    poke_unused_reg();
    send_byte(8'h01);
    drain_writes();

    // 8 bpp into a 2x2 rectangle on a zero-width line, then past the wrap.
    program_regs('0, '0, MODE_8BPP, '0, '0, RECT_W'(2), RECT_W'(2));
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
    send_byte(8'h7F); send_byte(8'h55);
    drain_writes();

    // Largest rectangle that is not clamped.
    program_regs(32'h8000_0000, LINE_W'(MAX_DIM), MODE_16BPP, ORG_W'(512), '0,
                 RECT_W'(MAX_DIM), RECT_W'(MAX_DIM));
    send_byte(8'hAA); send_byte(8'h55);

    // Random part: settings change per phase, idling cycles through four patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_writes();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      program_random_settings();
      n_bytes = $urandom_range(40, 80);
      for (int i = 0; i < n_bytes; i++) begin
        // Now and then hold off until the block has emptied.
        if ($urandom_range(0, 59) == 0) begin
          drain_writes();
          if ($urandom_range(0, 1) == 1) poke_unused_reg();
        end
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end

    drain_writes();
    repeat (8) @(posedge clk);
    $display("Sent %0d picture bytes under %0d register settings; %0d pixel writes checked.",
             bytes_sent, settings_count, writes_checked);
    $display("All pixel modes, clamped sizes, wrapped addresses and mid-pixel restarts ran.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
